@@ rtl/core/bpa_pkg.sv @@
// Shared types and constants for the bitmap page allocator.
// Used by bpa_ctrl, bpa_datapath and bitmap_page_allocator_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  localparam int MAX_PAGES   = 4096;
  localparam int PAGE_BYTES  = 4096;
  localparam int WORD_W      = 64;
  localparam int MAP_WORDS   = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W   = $clog2(WORD_W);
  localparam int PAGE_IDX_W  = WORD_IDX_W + BIT_IDX_W;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int ADDR_W      = 24;
  localparam int COUNT_W     = 13;
  localparam int FUNC_W      = 2;
  localparam int PTR_W       = WORD_IDX_W + 1;

  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 40;
  localparam int CFG_ADDR_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [COUNT_W-1:0] PAGE_LIMIT  = COUNT_W'(MAX_PAGES);
  localparam logic [COUNT_W-1:0] PAGES_RESET = 13'd4096;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_PAGES_IN_USE = 2'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic rd;
    logic eval;
    logic resp;
  } bpa_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_space;
  } bpa_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/bitmap_page_allocator_top.sv @@
// Allocate scans the words of the 64 x 64 occupancy map that hold pages below the limit, one
// word per cycle through its read port; free and mark-free pass through the read and evaluate
// states, an unknown function goes straight to response, and response waits while the result side holds off.
// Throughput: one word at a time; the next word is accepted once the result is registered.
// Reset: all pages used (row valid bits, no clearing pass), free count 0, pages_in_use 4096.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator_top
  import bpa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // s_tdata: func [1:0], page_addr [25:2], zero [31:26]
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // m_tdata: result_addr [23:0], granted [24], free_count [37:25], zero [39:38]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [COUNT_W-1:0] pages_in_use;
  bpa_cmd_t           cmd;
  bpa_stat_t          stat;
  logic [ADDR_W-1:0]  result_addr;
  logic               granted;
  logic [COUNT_W-1:0] free_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= PAGES_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_PAGES_IN_USE)) begin
      pages_in_use <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr == REG_PAGES_IN_USE) ? {{(32-COUNT_W){1'b0}}, pages_in_use} : '0;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_tvalid),
    .func      (s_tdata[FUNC_W-1:0]),
    .in_tready (s_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .pages_in_use (pages_in_use),
    .func         (s_tdata[FUNC_W-1:0]),
    .page_addr    (s_tdata[FUNC_W +: ADDR_W]),
    .out_tvalid   (m_tvalid),
    .out_tready   (m_tready),
    .result_addr  (result_addr),
    .granted      (granted),
    .free_count   (free_count)
  );

  assign m_tdata = {{(OUT_DATA_W-ADDR_W-1-COUNT_W){1'b0}}, free_count, granted, result_addr};

`ifndef ASSERT_OFF
  // The free count matches the number of free bits, so it never passes the map size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (free_count <= PAGE_LIMIT))
    else $error("free count above map size");

  // A new result word only appears out of the response state.
  a_resp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.resp))
    else $error("result word without response state");

  // Only one request is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a request is in work");

  // A result without a grant, from any function, reports address zero.
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !granted) |-> (result_addr == '0))
    else $error("non-zero address without grant");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bpa_ctrl.sv @@
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg; drives bpa_datapath through bpa_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl
  import bpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_tvalid,
  input  wire logic [FUNC_W-1:0] func,
  output logic                   in_tready,
  input  wire bpa_stat_t         stat,
  output bpa_cmd_t               cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD,
    S_EVAL,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_tvalid) begin
          case (func)
            FUNC_ALLOC: state_next = S_SCAN;
            FUNC_FREE:  state_next = S_RD;
            FUNC_MARK:  state_next = S_RD;
            default:    state_next = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (stat.hit || stat.scan_end) state_next = S_RESP;
      end
      S_RD:   state_next = S_EVAL;
      S_EVAL: state_next = S_RESP;
      S_RESP: begin
        if (stat.out_space) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    in_tready  = (state == S_IDLE);
    cmd.accept = in_tready && in_tvalid;
    cmd.scan   = (state == S_SCAN);
    cmd.rd     = (state == S_RD);
    cmd.eval   = (state == S_EVAL);
    cmd.resp   = (state == S_RESP);
  end

endmodule

`default_nettype wire

@@ rtl/core/bpa_datapath.sv @@
// Datapath of the bitmap page allocator: occupancy map memory, word scanner,
// free counter and output word register. Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpa_datapath
  import bpa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bpa_cmd_t              cmd,
  output bpa_stat_t                  stat,
  input  wire logic [COUNT_W-1:0]    pages_in_use,
  input  wire logic [FUNC_W-1:0]     func,
  input  wire logic [ADDR_W-1:0]     page_addr,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [ADDR_W-1:0]          result_addr,
  output logic                       granted,
  output logic [COUNT_W-1:0]         free_count
);

  // Occupancy map, one bit per page (1 = used). A row that was never
  // written reads as all used, which is the reset state of the map.
  logic [WORD_W-1:0]     map_mem [0:MAP_WORDS-1];
  logic [MAP_WORDS-1:0]  row_valid;

  logic [FUNC_W-1:0]     func_q;
  logic [PAGE_IDX_W-1:0] page_q;
  logic [PTR_W-1:0]      ptr;
  logic                  rd_pend;
  logic [WORD_IDX_W-1:0] rd_word;
  logic [WORD_W-1:0]     rdata;
  logic                  rdata_valid;
  logic [COUNT_W-1:0]    count;
  logic [ADDR_W-1:0]     res_addr;
  logic                  res_granted;

  logic [COUNT_W-1:0]    lim;
  logic [PTR_W-1:0]      nwords;
  logic [WORD_W-1:0]     word;
  logic [WORD_W-1:0]     elig;
  logic [WORD_W-1:0]     free_bits;
  logic [WORD_W-1:0]     onehot;
  logic [BIT_IDX_W-1:0]  hit_bit;
  logic                  issue_scan;
  logic                  rd_en;
  logic [WORD_IDX_W-1:0] rd_addr;
  logic                  free_ok;
  logic                  alloc_commit;
  logic                  free_commit;
  logic                  wr_en;
  logic [WORD_IDX_W-1:0] wr_addr;
  logic [WORD_W-1:0]     wr_data;
  logic [PTR_W-1:0]      rd_word_ext;

  always_comb begin
    lim = (pages_in_use > PAGE_LIMIT) ? PAGE_LIMIT : pages_in_use;
    nwords = lim[COUNT_W-1:BIT_IDX_W] + PTR_W'(|lim[BIT_IDX_W-1:0]);
    word = rdata_valid ? rdata : '1;
    rd_word_ext = {1'b0, rd_word};
    // Pages at or beyond the limit never count as free for the scan.
    if (rd_word_ext < lim[COUNT_W-1:BIT_IDX_W]) begin
      elig = '1;
    end else if (rd_word_ext == lim[COUNT_W-1:BIT_IDX_W]) begin
      elig = (WORD_W'(1) << lim[BIT_IDX_W-1:0]) - WORD_W'(1);
    end else begin
      elig = '0;
    end
    free_bits = ~word & elig;
    onehot = free_bits & (~free_bits + WORD_W'(1));
  end

  always_comb begin
    hit_bit = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (onehot[b]) hit_bit = hit_bit | BIT_IDX_W'(b);
    end
  end

  always_comb begin
    issue_scan   = cmd.scan && (ptr < nwords);
    rd_en        = issue_scan || cmd.rd;
    rd_addr      = cmd.rd ? page_q[PAGE_IDX_W-1:BIT_IDX_W] : ptr[WORD_IDX_W-1:0];
    stat.hit     = cmd.scan && rd_pend && (|free_bits);
    stat.scan_end = !rd_pend && (ptr >= nwords);
    stat.out_space = !out_tvalid || out_tready;
    alloc_commit = stat.hit;
    free_ok      = (func_q == FUNC_MARK) || ({1'b0, page_q} < lim);
    free_commit  = cmd.eval && free_ok && word[page_q[BIT_IDX_W-1:0]];
    wr_en        = alloc_commit || free_commit;
    wr_addr      = alloc_commit ? rd_word : page_q[PAGE_IDX_W-1:BIT_IDX_W];
    wr_data      = alloc_commit ? (word | onehot)
                                : (word & ~(WORD_W'(1) << page_q[BIT_IDX_W-1:0]));
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata       <= map_mem[rd_addr];
      rdata_valid <= row_valid[rd_addr];
    end
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      rd_pend <= 1'b0;
      count   <= '0;
    end else begin
      if (cmd.accept) begin
        ptr     <= '0;
        rd_pend <= 1'b0;
      end else if (cmd.scan) begin
        rd_pend <= issue_scan;
        if (issue_scan) ptr <= ptr + PTR_W'(1);
      end
      if (alloc_commit && (count != '0)) begin
        count <= count - COUNT_W'(1);
      end else if (free_commit && (count != COUNT_MAX)) begin
        count <= count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) rd_word <= ptr[WORD_IDX_W-1:0];
    if (cmd.accept) begin
      func_q      <= func;
      page_q      <= page_addr[PAGE_SHIFT +: PAGE_IDX_W];
      res_addr    <= '0;
      res_granted <= 1'b0;
    end else if (alloc_commit) begin
      res_addr    <= {rd_word, hit_bit, {PAGE_SHIFT{1'b0}}};
      res_granted <= 1'b1;
    end else if (free_commit) begin
      res_granted <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.resp && stat.out_space) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp && stat.out_space) begin
      result_addr <= res_addr;
      granted     <= res_granted;
      free_count  <= count;
    end
  end

endmodule

`default_nettype wire

@@ test/bitmap_page_allocator_top_tb.sv @@
// Self-checking testbench for bitmap_page_allocator_top: directed table, then random phases.
// It predicts results from its own map or takes the table's. Depends on bpa_pkg and the RTL.
`timescale 1ns / 1ps

module bitmap_page_allocator_top_tb;
  import bpa_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int LONG_HOLD       = 600;
  localparam int TAIL_CYCLES     = 80;
  // The slowest legal run is roughly 2000 words, each with the longest scan and gaps.
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int REPORT_CAP      = 40;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               granted;
    logic [ADDR_W-1:0]  addr;
  } page_result_t;

  typedef struct packed {
    bit                 is_cfg;
    bit                 known;
    logic [FUNC_W-1:0]  func;
    logic [ADDR_W-1:0]  addr;
    page_result_t       want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  bitmap_page_allocator_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Shadow of the allocator state.
  logic [MAX_PAGES-1:0] page_used = '1;
  logic [COUNT_W-1:0]   free_total = '0;
  logic [COUNT_W-1:0]   page_limit = PAGES_RESET;

  page_result_t frame_q[$];
  dir_row_t     dir_rows[$];

  int  errors = 0;
  int  idle_pct = 25;
  bit  long_hold_req = 1'b0;
  int  cycle_count = 0;
  int  n_requests = 0;
  int  n_words = 0;
  int  n_alloc_ok = 0;
  int  n_alloc_fail = 0;
  int  n_released = 0;
  int  n_ignored = 0;
  int  n_limits = 0;

  int phase_limit [0:NUM_PHASES-1] = '{4096, 64, 8191, 1, 130, 0, 257, 4095, 100, 640};
  int phase_idle  [0:NUM_PHASES-1] = '{30, 0, 50, 20, 30, 0, 40, 25, 10, 35};

  function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    errors++;
    if (errors <= REPORT_CAP)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
  endfunction

  function automatic bit release_frame(input int pg);
    if (!page_used[pg]) return 1'b0;
    page_used[pg] = 1'b0;
    if (free_total != COUNT_MAX) free_total++;
    return 1'b1;
  endfunction

  function automatic page_result_t predict_request(input logic [FUNC_W-1:0] f,
                                                   input logic [ADDR_W-1:0] a);
    page_result_t r;
    int lim;
    int pg;
    r = '0;
    lim = (page_limit > MAX_PAGES) ? MAX_PAGES : int'(page_limit);
    pg = int'(a >> PAGE_SHIFT);
    case (f)
      FUNC_ALLOC: begin
        // First fit: the lowest free page below the limit.
        for (int i = 0; i < lim; i++) begin
          if (!page_used[i]) begin
            page_used[i] = 1'b1;
            if (free_total != 0) free_total--;
            r.addr = ADDR_W'(i * PAGE_BYTES);
            r.granted = 1'b1;
            break;
          end
        end
      end
      FUNC_FREE: if (pg < lim) r.granted = release_frame(pg);
      // Boot release covers the whole map, whatever the managed page count.
      FUNC_MARK: if (pg < MAX_PAGES) r.granted = release_frame(pg);
      default: ;
    endcase
    r.count = free_total;
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
  endfunction

  function automatic dir_row_t row_known(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                                         input logic [ADDR_W-1:0] ea, input logic eg,
                                         input logic [COUNT_W-1:0] ec);
    dir_row_t d;
    d = '0;
    d.known = 1'b1;
    d.func = f;
    d.addr = a;
    d.want = '{count: ec, granted: eg, addr: ea};
    return d;
  endfunction

  function automatic dir_row_t row_open(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a);
    dir_row_t d;
    d = '0;
    d.func = f;
    d.addr = a;
    return d;
  endfunction

  function automatic dir_row_t row_limit(input logic [COUNT_W-1:0] v);
    dir_row_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.addr = ADDR_W'(v);
    return d;
  endfunction

  // Offers one request word and records its predicted result once it is taken.
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                           input bit known, input page_result_t want);
    page_result_t r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({a, f});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_request(f, a);
    if (known) r = want;
    frame_q.push_back(r);
    n_requests++;
    case (f)
      FUNC_ALLOC: if (r.granted) n_alloc_ok++; else n_alloc_fail++;
      FUNC_FREE, FUNC_MARK: if (r.granted) n_released++; else n_ignored++;
      default: n_ignored++;
    endcase
  endtask

  // Writes the managed page count once the block has gone quiet, then reads it back.
  task automatic set_page_limit(input logic [COUNT_W-1:0] v);
    s_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_PAGES_IN_USE;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    page_limit = v;
    n_limits++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(v)) note_mismatch("pages_in_use read-back", 32'(v), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    page_result_t got;
    page_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[COUNT_W+ADDR_W:0];
      n_words++;
      if (frame_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result word with none expected, expected nothing, got %0h",
                   $time, got);
      end else begin
        want = frame_q.pop_front();
        if (got.addr !== want.addr) note_mismatch("result_addr", want.addr, got.addr);
        if (got.granted !== want.granted) note_mismatch("granted", want.granted, got.granted);
        if (got.count !== want.count) note_mismatch("free_count", want.count, got.count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, frame_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int lim_eff;
    int span;
    int page;
    int pick;
    logic [FUNC_W-1:0] f;
    logic [ADDR_W-1:0] a;

    // After reset every page is used, the count is zero and 4096 pages are managed.
    dir_rows.push_back(row_known(FUNC_ALLOC,  24'h000000, 24'h000000, 1'b0, 13'd0));
    dir_rows.push_back(row_known(FUNC_FREE,   24'h000000, 24'h000000, 1'b1, 13'd1));
    dir_rows.push_back(row_known(FUNC_FREE,   24'h000FFF, 24'h000000, 1'b0, 13'd1));
    dir_rows.push_back(row_known(FUNC_ALLOC,  24'hFFFFFF, 24'h000000, 1'b1, 13'd0));
    dir_rows.push_back(row_known(FUNC_MARK,   24'hFFFFFF, 24'h000000, 1'b1, 13'd1));
    dir_rows.push_back(row_known(FUNC_MARK,   24'hFFF000, 24'h000000, 1'b0, 13'd1));
    dir_rows.push_back(row_known(FUNC_ALLOC,  24'h000000, 24'hFFF000, 1'b1, 13'd0));
    dir_rows.push_back(row_known(FUNC_ALLOC,  24'h123456, 24'h000000, 1'b0, 13'd0));
    dir_rows.push_back(row_known(FUNC_UNUSED, 24'hABCDEF, 24'h000000, 1'b0, 13'd0));
    dir_rows.push_back(row_known(FUNC_MARK,   24'h001000, 24'h000000, 1'b1, 13'd1));
    dir_rows.push_back(row_known(FUNC_MARK,   24'h002FFF, 24'h000000, 1'b1, 13'd2));
    dir_rows.push_back(row_known(FUNC_FREE,   24'h001234, 24'h000000, 1'b0, 13'd2));
    dir_rows.push_back(row_known(FUNC_ALLOC,  24'h000000, 24'h001000, 1'b1, 13'd1));
    // Only pages 0 and 1 managed: a free above is ignored, a boot release is not.
    dir_rows.push_back(row_limit(13'd2));
    dir_rows.push_back(row_known(FUNC_FREE,   24'h005000, 24'h000000, 1'b0, 13'd1));
    dir_rows.push_back(row_known(FUNC_MARK,   24'h005000, 24'h000000, 1'b1, 13'd2));
    dir_rows.push_back(row_known(FUNC_ALLOC,  24'h000000, 24'h000000, 1'b0, 13'd2));
    dir_rows.push_back(row_limit(13'd0));
    dir_rows.push_back(row_known(FUNC_ALLOC,  24'h000000, 24'h000000, 1'b0, 13'd2));
    dir_rows.push_back(row_known(FUNC_FREE,   24'h000000, 24'h000000, 1'b0, 13'd2));
    // A limit above the map size is clipped to the map.
    dir_rows.push_back(row_limit(13'd8191));
    dir_rows.push_back(row_known(FUNC_ALLOC,  24'h000000, 24'h002000, 1'b1, 13'd1));
    dir_rows.push_back(row_open(FUNC_FREE,    24'h001800));
    dir_rows.push_back(row_open(FUNC_MARK,    24'h7FF123));
    dir_rows.push_back(row_open(FUNC_ALLOC,   24'h000000));
    dir_rows.push_back(row_open(FUNC_UNUSED,  24'h555555));
    dir_rows.push_back(row_open(FUNC_ALLOC,   24'h000000));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg)
        set_page_limit(dir_rows[k].addr[COUNT_W-1:0]);
      else
        send_word(dir_rows[k].func, dir_rows[k].addr, dir_rows[k].known, dir_rows[k].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_page_limit(COUNT_W'(phase_limit[p]));
      idle_pct = phase_idle[p];
      lim_eff = (phase_limit[p] > MAX_PAGES) ? MAX_PAGES : phase_limit[p];
      span = (lim_eff + 8 > MAX_PAGES) ? MAX_PAGES : lim_eff + 8;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // The result side stops for a long while here and the input backs up behind it.
        if (p == 1 && n == 40) long_hold_req = 1'b1;
        if ($urandom_range(0, 149) == 0 && frame_q.size() != 0) begin
          s_tvalid <= 1'b0;
          while (frame_q.size() != 0) @(posedge clk);
        end
        pick = $urandom_range(0, 19);
        f = (pick < 8) ? FUNC_ALLOC : (pick < 13) ? FUNC_FREE :
            (pick < 19) ? FUNC_MARK : FUNC_UNUSED;
        // Mostly pages near the managed range, so that releases and allocations meet.
        pick = $urandom_range(0, 9);
        if (pick < 6) page = $urandom_range(0, span - 1);
        else if (pick < 8) page = $urandom_range(0, 63);
        else page = $urandom_range(0, MAX_PAGES - 1);
        a = (ADDR_W'(page) << PAGE_SHIFT) | ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
        send_word(f, a, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests over %0d page-count settings; %0d result words checked.",
             n_requests, n_limits, n_words);
    $display("Allocations %0d granted, %0d refused; %0d pages released, %0d requests ignored.",
             n_alloc_ok, n_alloc_fail, n_released, n_ignored);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
